>>> rtl/core/jfs_pkg.sv
// Shared types, constants and helpers for the five-point Jacobi sweep block.
`timescale 1ns / 1ps
`default_nettype none

package jfs_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DataW   = 32;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;

  // Default buffer and counter sizes.
  localparam int unsigned DefMaxCols = 1024;
  localparam int unsigned DefMaxRows = 1024;

  // Smallest grid dimension, boundary ring included.
  localparam int unsigned MinDim = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgGridRows = 1'b0,
    CfgGridCols = 1'b1
  } cfg_reg_e;

  // Position of the incoming item in the raster and what it causes.
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } jfs_pos_t;

  // Clamps a written dimension to [MinDim, hi] and returns that value minus one.
  function automatic logic [31:0] dim_last(logic [CfgW-1:0] v, int unsigned hi);
    logic [31:0] wide;
    wide = {{(32 - CfgW){1'b0}}, v};
    if (wide < MinDim) begin
      return MinDim - 1;
    end else if (wide > hi) begin
      return hi - 1;
    end else begin
      return wide - 32'd1;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/jfs_raster.sv
// Grid size registers and the row and column counters of the raster scan.
`timescale 1ns / 1ps
`default_nettype none

module jfs_raster #(
  parameter int unsigned MAX_COLS = jfs_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = jfs_pkg::DefMaxRows,
  localparam int unsigned ColW = $clog2(MAX_COLS),
  localparam int unsigned RowW = $clog2(MAX_ROWS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [jfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [jfs_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        accept_i,
  output jfs_pkg::jfs_pos_t                pos_o,
  output logic [ColW-1:0]                  col_o,
  output logic [ColW-1:0]                  col_next_o
);
  import jfs_pkg::*;

  logic [RowW-1:0] rows_last_q, rows_last_d;
  logic [ColW-1:0] cols_last_q, cols_last_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [31:0]     rows_clamped;
  logic [31:0]     cols_clamped;
  logic [31:0]     row_minus1;
  logic [31:0]     col_wide;
  logic            row_end;
  logic            sweep_end;

  assign rows_clamped = dim_last(cfg_wdata_i, MAX_ROWS);
  assign cols_clamped = dim_last(cfg_wdata_i, MAX_COLS);

  // Configuration writes update a dimension and restart the sweep.
  always_comb begin
    rows_last_d = rows_last_q;
    cols_last_d = cols_last_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgGridRows: rows_last_d = rows_clamped[RowW-1:0];
        CfgGridCols: cols_last_d = cols_clamped[ColW-1:0];
        default: ;
      endcase
    end
  end

  assign row_end   = (col_q == cols_last_q);
  assign sweep_end = row_end && (row_q == rows_last_q);

  // Raster counters: columns wrap at the row end, rows at the sweep end.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = sweep_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= RowW'(MinDim - 1);
      cols_last_q <= ColW'(MinDim - 1);
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      rows_last_q <= rows_last_d;
      cols_last_q <= cols_last_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

  // The item at (r, c) completes the interior cell (r - 1, c).
  assign row_minus1 = 32'(row_q) - 32'd1;
  assign col_wide   = 32'(col_q);

  always_comb begin
    pos_o.emit = (row_q >= RowW'(2)) && (col_q != '0) && !row_end;
    pos_o.last = (row_q == rows_last_q) && (col_q == cols_last_q - ColW'(1));
    pos_o.row  = row_minus1[CoordW-1:0];
    pos_o.col  = col_wide[CoordW-1:0];
  end

  assign col_o      = col_q;
  assign col_next_o = col_d;

endmodule

`default_nettype wire

>>> rtl/core/jfs_line_buf.sv
// Two line buffers and the stencil window around the incoming item.
`timescale 1ns / 1ps
`default_nettype none

module jfs_line_buf #(
  parameter int unsigned MAX_COLS = jfs_pkg::DefMaxCols,
  localparam int unsigned ColW = $clog2(MAX_COLS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [ColW-1:0]            wr_addr_i,
  input  wire logic [jfs_pkg::DataW-1:0]  cell_value_i,
  input  wire logic [ColW-1:0]            rd_addr_i,
  output logic [jfs_pkg::DataW-1:0]       up_o,
  output logic [jfs_pkg::DataW-1:0]       center_o,
  output logic [jfs_pkg::DataW-1:0]       right_o,
  output logic [jfs_pkg::DataW-1:0]       left_o
);
  import jfs_pkg::*;

  logic [DataW-1:0] upper_mem  [MAX_COLS];
  logic [DataW-1:0] middle_mem [MAX_COLS];
  logic [DataW-1:0] up_q;
  logic [DataW-1:0] center_q;
  logic [DataW-1:0] right_q;
  logic [DataW-1:0] left_q;
  logic [ColW-1:0]  rd_right_addr;

  // The right neighbor sits one column ahead; the last column never needs it.
  assign rd_right_addr = (rd_addr_i == ColW'(MAX_COLS - 1)) ? '0 : rd_addr_i + ColW'(1);

  // Reads follow the next column every cycle, so the window is ready when the
  // item for that column arrives. A read never hits the column being written.
  always_ff @(posedge clk_i) begin
    up_q     <= upper_mem[rd_addr_i];
    center_q <= middle_mem[rd_addr_i];
    right_q  <= middle_mem[rd_right_addr];
  end

  // An accepted item is stored in the middle line; that column's old value moves to the upper line and the left slot.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= center_q;
      middle_mem[wr_addr_i] <= cell_value_i;
      left_q                <= center_q;
    end
  end

  assign up_o     = up_q;
  assign center_o = center_q;
  assign right_o  = right_q;
  assign left_o   = left_q;

endmodule

`default_nettype wire

>>> rtl/core/jfs_update.sv
// Stencil arithmetic, running maximum of the change and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module jfs_update (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       take_i,
  input  wire jfs_pkg::jfs_pos_t          pos_i,
  input  wire logic [jfs_pkg::DataW-1:0]  down_i,
  input  wire logic [jfs_pkg::DataW-1:0]  up_i,
  input  wire logic [jfs_pkg::DataW-1:0]  left_i,
  input  wire logic [jfs_pkg::DataW-1:0]  right_i,
  input  wire logic [jfs_pkg::DataW-1:0]  center_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [jfs_pkg::DataW-1:0]       new_value_o,
  output logic [jfs_pkg::CoordW-1:0]      cell_row_o,
  output logic [jfs_pkg::CoordW-1:0]      cell_col_o,
  output logic [jfs_pkg::DataW-1:0]       max_change_o,
  output logic                            last_of_sweep_o
);
  import jfs_pkg::*;

  // Stage A: the item with its neighbors already summed in pairs.
  logic                     a_valid_q, a_valid_d;
  logic signed [DataW:0]    a_sum_ud_q;
  logic signed [DataW:0]    a_sum_lr_q;
  logic [DataW-1:0]         a_center_q;
  jfs_pos_t                 a_pos_q;
  logic                     a_go;

  // Result register and running maximum.
  logic                     out_valid_q, out_valid_d;
  logic [DataW-1:0]         new_value_q;
  logic [CoordW-1:0]        cell_row_q;
  logic [CoordW-1:0]        cell_col_q;
  logic [DataW-1:0]         max_out_q;
  logic                     last_q;
  logic [DataW-1:0]         run_max_q, run_max_d;

  logic signed [DataW+1:0]  sum;
  logic [DataW-1:0]         nv;
  logic signed [DataW:0]    diff_pos;
  logic signed [DataW:0]    diff_neg;
  logic [DataW:0]           abs_wide;
  logic [DataW-1:0]         abs_chg;
  logic [DataW-1:0]         new_max;
  logic                     out_blocked;

  // Stage A moves on whenever the result register is free or being emptied.
  assign out_blocked = out_valid_q && out_stall_i;
  assign a_go        = a_valid_q && !out_blocked;
  assign busy_o      = a_valid_q && out_blocked;

  always_comb begin
    a_valid_d = a_valid_q;
    if (take_i) begin
      a_valid_d = 1'b1;
    end else if (a_go) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (a_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Quarter of the four-neighbor sum, rounding toward minus infinity.
  assign sum = {a_sum_ud_q[DataW], a_sum_ud_q} + {a_sum_lr_q[DataW], a_sum_lr_q};
  assign nv  = sum[DataW+1:2];

  // Absolute change, both differences formed side by side; it always fits 32 bits.
  assign diff_pos = $signed({nv[DataW-1], nv}) - $signed({a_center_q[DataW-1], a_center_q});
  assign diff_neg = $signed({a_center_q[DataW-1], a_center_q}) - $signed({nv[DataW-1], nv});
  assign abs_wide = diff_pos[DataW] ? diff_neg : diff_pos;
  assign abs_chg  = abs_wide[DataW-1:0];
  assign new_max  = (abs_chg > run_max_q) ? abs_chg : run_max_q;

  // The maximum starts over after the last interior cell and on any configuration write.
  always_comb begin
    run_max_d = run_max_q;
    if (clear_i) begin
      run_max_d = '0;
    end else if (a_go) begin
      run_max_d = a_pos_q.last ? '0 : new_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      run_max_q   <= '0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      run_max_q   <= run_max_d;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      a_sum_ud_q <= $signed({up_i[DataW-1], up_i}) + $signed({down_i[DataW-1], down_i});
      a_sum_lr_q <= $signed({left_i[DataW-1], left_i}) + $signed({right_i[DataW-1], right_i});
      a_center_q <= center_i;
      a_pos_q    <= pos_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      new_value_q <= nv;
      cell_row_q  <= a_pos_q.row;
      cell_col_q  <= a_pos_q.col;
      max_out_q   <= new_max;
      last_q      <= a_pos_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_value_o     = new_value_q;
  assign cell_row_o      = cell_row_q;
  assign cell_col_o      = cell_col_q;
  assign max_change_o    = max_out_q;
  assign last_of_sweep_o = last_q;

endmodule

`default_nettype wire

>>> rtl/core/jacobi_five_point_sweep.sv
// Top level of the streaming five-point Jacobi sweep over a raster-ordered grid.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid_i / in_stall_o  cell_value_i
//   out       source     out_valid_o / out_stall_i new_value_o, cell_row_o, cell_col_o,
//                                                max_change_o, last_of_sweep_o
//   cfg       sink       cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One item is taken per cycle unless the input stalls; a result passes through
// the pair-sum register and then the result register behind the line buffer reads.
// Boundary cells produce no result and never hold up the input.
// Reset clears the counters, the running maximum and the valid flags; the line
// buffers need no clearing since each entry is written before it is used.
// The input stalls only when both the pair-sum stage and the result register are full
// and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_five_point_sweep #(
  parameter int unsigned MAX_COLS = jfs_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = jfs_pkg::DefMaxRows
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [jfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [jfs_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [jfs_pkg::DataW-1:0]   cell_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [jfs_pkg::DataW-1:0]        new_value_o,
  output logic [jfs_pkg::CoordW-1:0]       cell_row_o,
  output logic [jfs_pkg::CoordW-1:0]       cell_col_o,
  output logic [jfs_pkg::DataW-1:0]        max_change_o,
  output logic                             last_of_sweep_o
);
  import jfs_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLS);

  logic             accept;
  logic             busy;
  jfs_pos_t         pos;
  logic [ColW-1:0]  col;
  logic [ColW-1:0]  col_next;
  logic [DataW-1:0] up;
  logic [DataW-1:0] center;
  logic [DataW-1:0] right;
  logic [DataW-1:0] left;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Raster position and grid size.
  jfs_raster #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .pos_o       (pos),
    .col_o       (col),
    .col_next_o  (col_next)
  );

  // Line buffers and neighbor window.
  jfs_line_buf #(
    .MAX_COLS (MAX_COLS)
  ) u_line_buf (
    .clk_i        (clk_i),
    .wr_en_i      (accept),
    .wr_addr_i    (col),
    .cell_value_i (cell_value_i),
    .rd_addr_i    (col_next),
    .up_o         (up),
    .center_o     (center),
    .right_o      (right),
    .left_o       (left)
  );

  // Arithmetic and output stage.
  jfs_update u_update (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (cfg_we_i),
    .take_i          (accept && pos.emit),
    .pos_i           (pos),
    .down_i          (cell_value_i),
    .up_i            (up),
    .left_i          (left),
    .right_i         (right),
    .center_i        (center),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_value_o     (new_value_o),
    .cell_row_o      (cell_row_o),
    .cell_col_o      (cell_col_o),
    .max_change_o    (max_change_o),
    .last_of_sweep_o (last_of_sweep_o)
  );

  // The input only stalls behind a full, stalled output.
  a_stall_needs_full_out : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o
  ) else $error("input stalled while the result register is empty");

  // A new grid size restarts at the top row, where nothing is emitted.
  a_cfg_restarts_sweep : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> !pos.emit
  ) else $error("interior result due right after a configuration write");

  // Results only ever name interior cells.
  a_interior_only : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (cell_row_o != '0) && (cell_col_o != '0)
  ) else $error("result names a boundary cell");

endmodule

`default_nettype wire

>>> tb/jacobi_five_point_sweep_tb.sv
// Self-checking testbench for the streaming five-point Jacobi sweep block.
`timescale 1ns / 1ps

module jacobi_five_point_sweep_tb;
  import jfs_pkg::*;

  localparam int unsigned MaxCols      = DefMaxCols;
  localparam int unsigned MaxRows      = DefMaxRows;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems  = 420;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned MaxReports   = 10;

  // One updated interior cell as the block reports it.
  typedef struct packed {
    logic [DataW-1:0]  value;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [DataW-1:0]  peak;
    logic              last;
  } cell_update_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [DataW-1:0]    cell_value_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [DataW-1:0]    new_value_o;
  logic [CoordW-1:0]   cell_row_o;
  logic [CoordW-1:0]   cell_col_o;
  logic [DataW-1:0]    max_change_o;
  logic                last_of_sweep_o;

  // Mirror of the block's grid state, kept by the predictor.
  logic [CfgW-1:0]     grid_rows_q = CfgW'(MinDim);
  logic [CfgW-1:0]     grid_cols_q = CfgW'(MinDim);
  int unsigned         row_pos     = 0;
  int unsigned         col_pos     = 0;
  logic [DataW-1:0]    peak_change = '0;
  logic [DataW-1:0]    left_cell   = '0;
  logic [DataW-1:0]    upper_row [MaxCols] = '{default: '0};
  logic [DataW-1:0]    middle_row [MaxCols] = '{default: '0};

  cell_update_t        expected_updates [$];
  int unsigned         error_count  = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_stall_pct = 0;
  int unsigned         stall_hold   = 0;

  jacobi_five_point_sweep #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cell_value_i   (cell_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_value_o    (new_value_o),
    .cell_row_o     (cell_row_o),
    .cell_col_o     (cell_col_o),
    .max_change_o   (max_change_o),
    .last_of_sweep_o(last_of_sweep_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[jacobi_five_point_sweep] ERROR");
    $finish;
  end

  // Effective grid dimension after clamping to the supported range.
  function automatic int unsigned eff_dim(input logic [CfgW-1:0] v, input int unsigned hi);
    int unsigned w;
    w = v;
    if (w < MinDim) return MinDim;
    if (w > hi) return hi;
    return w;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap(input int unsigned pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random cell value: full range, small magnitudes and the extremes.
  function automatic logic [DataW-1:0] rand_cell();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2: v = $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Clears the sweep position, as any register write does.
  function automatic void restart_grid();
    row_pos     = 0;
    col_pos     = 0;
    peak_change = '0;
    left_cell   = '0;
  endfunction

  // Advances the grid model by one accepted cell and queues the update it causes.
  function automatic void predict_cell(input logic [DataW-1:0] x);
    int unsigned              rows_e;
    int unsigned              cols_e;
    int unsigned              r;
    int unsigned              c;
    logic [DataW-1:0]         center;
    logic [DataW-1:0]         up;
    logic [DataW-1:0]         right;
    logic signed [DataW+1:0]  sum;
    logic [DataW:0]           delta;
    logic [DataW:0]           mag;
    logic [DataW-1:0]         mag_sat;
    cell_update_t             upd;
    rows_e = eff_dim(grid_rows_q, MaxRows);
    cols_e = eff_dim(grid_cols_q, MaxCols);
    r = row_pos;
    c = col_pos;
    if (c >= cols_e) c = cols_e - 1;
    if (r >= rows_e) r = rows_e - 1;
    center = middle_row[c];
    up     = upper_row[c];
    right  = (c + 1 < MaxCols) ? middle_row[c + 1] : '0;

    // Interior cell one row up: quarter of the neighbor sum, floored.
    if (r >= 2 && c >= 1 && c + 2 <= cols_e) begin
      sum = {{2{up[DataW-1]}}, up} + {{2{x[DataW-1]}}, x}
          + {{2{left_cell[DataW-1]}}, left_cell} + {{2{right[DataW-1]}}, right};
      upd.value = sum[DataW+1:2];
      delta = {upd.value[DataW-1], upd.value} - {center[DataW-1], center};
      mag = delta[DataW] ? (~delta + 1'b1) : delta;
      mag_sat = mag[DataW] ? '1 : mag[DataW-1:0];
      if (mag_sat > peak_change) peak_change = mag_sat;
      upd.row  = CoordW'(r - 1);
      upd.col  = CoordW'(c);
      upd.peak = peak_change;
      upd.last = (r + 1 == rows_e) && (c + 2 == cols_e);
      expected_updates.push_back(upd);
    end

    left_cell     = center;
    upper_row[c]  = center;
    middle_row[c] = x;

    // Raster position; wrap at the end of a row and of the grid.
    if (c + 1 >= cols_e) begin
      col_pos   = 0;
      left_cell = '0;
      if (r + 1 >= rows_e) begin
        row_pos     = 0;
        peak_change = '0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // Output side: random stalls, and every accepted result checked in order.
  always @(posedge clk_i) begin
    cell_update_t got;
    cell_update_t want;
    int unsigned  g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{new_value_o, cell_row_o, cell_col_o, max_change_o, last_of_sweep_o};
      if (expected_updates.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t: unexpected result val=%h row=%0d col=%0d max=%h last=%b",
                   $realtime, got.value, got.row, got.col, got.peak, got.last);
        end
      end else begin
        want = expected_updates.pop_front();
        if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
            got.peak !== want.peak || got.last !== want.last) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: mismatch exp val=%h row=%0d col=%0d max=%h last=%b",
                     $realtime, want.value, want.row, want.col, want.peak, want.last);
            $display("%0t:          got val=%h row=%0d col=%0d max=%h last=%b",
                     $realtime, got.value, got.row, got.col, got.peak, got.last);
          end
        end
      end
    end
    if (stall_hold > 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else begin
      g = pick_gap(rx_stall_pct);
      out_stall_i <= (g > 0);
      stall_hold = (g > 0) ? g - 1 : 0;
    end
  end

  // Sends one cell item; valid is left high so back-to-back items need no drop.
  task automatic send_cell(input logic [DataW-1:0] value);
    int unsigned gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid_i   <= 1'b0;
      cell_value_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    predict_cell(value);
  endtask

  // Sends a run of random cells.
  task automatic run_sweep(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_cell(rand_cell());
    end
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline drain.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one configuration register; the block must be idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CfgGridRows) grid_rows_q = val;
    else grid_cols_q = val;
    restart_grid();
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CfgW'($urandom);
    @(posedge clk_i);
  endtask

  // Two 3x3 sweeps at reset size: largest change, then floor rounding and peak clear.
  task automatic test_boundary_extremes();
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    for (int i = 0; i < 9; i++) begin
      send_cell((i == 4) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end
    for (int i = 0; i < 9; i++) begin
      send_cell((i == 4) ? 32'h0000_0000 : ((i == 1) ? 32'h0000_0001 : 32'hFFFF_FFFF));
    end
    settle_idle();
  endtask

  // Dimensions below the minimum act as the minimum.
  task automatic test_register_clamping();
    write_reg(CfgGridRows, 11'd2);
    write_reg(CfgGridCols, 11'd0);
    run_sweep(9);
    settle_idle();
  endtask

  // A register write in the middle of a sweep starts a fresh one.
  task automatic test_restart_mid_sweep();
    tx_idle_pct  = 40;
    rx_stall_pct = 40;
    write_reg(CfgGridRows, 11'd5);
    write_reg(CfgGridCols, 11'd7);
    run_sweep(20);
    settle_idle();
    write_reg(CfgGridCols, 11'd7);
    run_sweep(35);
    settle_idle();
    write_reg(CfgGridRows, 11'd4);
    run_sweep(28);
    settle_idle();
  endtask

  // Tallest and widest grids from oversize writes, each fed for the start of a sweep.
  task automatic test_largest_grids();
    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    write_reg(CfgGridRows, 11'h7FF);
    write_reg(CfgGridCols, 11'd3);
    run_sweep(180);
    settle_idle();
    write_reg(CfgGridRows, 11'd3);
    write_reg(CfgGridCols, 11'd1025);
    run_sweep(90);
    settle_idle();
  endtask

  // Random small grids, one to three sweeps each, some cut short.
  task automatic test_random_sweeps();
    int unsigned sent;
    int unsigned which;
    int unsigned full;
    int unsigned cnt;
    logic [CfgW-1:0] rows_w;
    logic [CfgW-1:0] cols_w;
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 3))
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 20; rx_stall_pct = 50; end
        2:       begin tx_idle_pct = 50; rx_stall_pct = 20; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      rows_w = ($urandom_range(0, 7) == 0) ? CfgW'($urandom_range(0, 2))
                                           : CfgW'($urandom_range(3, 9));
      cols_w = ($urandom_range(0, 7) == 0) ? CfgW'($urandom_range(0, 2))
                                           : CfgW'($urandom_range(3, 14));
      which = $urandom_range(0, 2);
      if (which != 2) write_reg(CfgGridRows, rows_w);
      if (which != 1) write_reg(CfgGridCols, cols_w);
      full = eff_dim(grid_rows_q, MaxRows) * eff_dim(grid_cols_q, MaxCols);
      repeat ($urandom_range(1, 3)) begin
        cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, full - 1) : full;
        run_sweep(cnt);
        sent += cnt;
      end
      settle_idle();
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundary_extremes();
    test_register_clamping();
    test_restart_mid_sweep();
    test_largest_grids();
    test_random_sweeps();
    settle_idle();
    if (error_count == 0 && expected_updates.size() == 0) begin
      $display("[jacobi_five_point_sweep] OK");
    end else begin
      $display("[jacobi_five_point_sweep] ERROR");
    end
    $finish;
  end

endmodule

>>> jacobi_five_point_sweep.f
rtl/core/jfs_pkg.sv
rtl/core/jfs_raster.sv
rtl/core/jfs_line_buf.sv
rtl/core/jfs_update.sv
rtl/core/jacobi_five_point_sweep.sv
tb/jacobi_five_point_sweep_tb.sv
